[rtl/ele_pkg.sv]
package ele_pkg;

    localparam int COEF_W     = 20;
    localparam int PT_W       = 20;
    localparam int ROW_W      = 60;
    localparam int FOC_W      = 16;
    localparam int ERR_W      = 32;
    localparam int CFG_IDX_W  = 2;

    localparam int LINE_W     = 42;
    localparam int D_W        = 63;
    localparam int MAG_W      = 40;
    localparam int DEN_W      = 81;
    localparam int DMAG_W     = 62;
    localparam int DSQ_W      = 124;
    localparam int NUM_W      = 156;
    localparam int NH_W       = 124;
    localparam int REM_W      = 82;
    localparam int DIV_STAGES = 32;

    // ten arithmetic stages, the divider stages and the output register
    localparam int PIPE_DEPTH = 11 + DIV_STAGES;

    localparam logic [CFG_IDX_W-1:0] REG_E_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_E_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_E_ROW2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 2'd3;

    localparam logic [FOC_W-1:0] FOCAL_RESET = 16'd8000;
    localparam logic [ERR_W-1:0] ERR_SAT     = 32'hFFFF_FFFF;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PT_W-1:0]   pt_t;
    typedef logic signed [LINE_W-1:0] line_t;

endpackage

[rtl/epipolar_line_error.sv]
// Symmetric epipolar distance scorer. Each item is one point correspondence
// (first_x, first_y, second_x, second_y, signed Q3.16 each) checked against the
// essential matrix held in e_row0..e_row2; the result is the larger squared
// point-to-line distance in squared pixels (unsigned Q32.0, saturating) and a
// degenerate flag when either line normal is zero. The block takes one item
// every clock cycle while the output is not stalled; each item passes through ten
// multiply and add stages, then a 32-stage restoring divider per side (one
// quotient bit per stage), then the output register. The whole pipe holds
// while a result waits on m_tready, so nothing is dropped. Configuration
// writes take effect at once and must only be made while the pipe is empty.
module epipolar_line_error (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ele_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ele_pkg::ROW_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // first_x, first_y, second_x, second_y
    input  logic [79:0]                       s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // error_squared
    output logic [31:0]                       m_tdata,
    // degenerate
    output logic [0:0]                        m_tuser
);

    localparam int ND = ele_pkg::DIV_STAGES;

    logic [ele_pkg::ROW_W-1:0] e_row_reg [3];
    logic [ele_pkg::FOC_W-1:0] focal_reg;
    logic [31:0]               f2_reg;
    logic [ele_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic ce;

    assign ce       = !vld_reg[ele_pkg::PIPE_DEPTH-1] || m_tready;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_row_reg[0] <= '0;
            e_row_reg[1] <= '0;
            e_row_reg[2] <= '0;
            focal_reg    <= ele_pkg::FOCAL_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ele_pkg::REG_E_ROW0: e_row_reg[0] <= cfg_wdata;
                ele_pkg::REG_E_ROW1: e_row_reg[1] <= cfg_wdata;
                ele_pkg::REG_E_ROW2: e_row_reg[2] <= cfg_wdata;
                ele_pkg::REG_FOCAL:  focal_reg    <= cfg_wdata[ele_pkg::FOC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        f2_reg <= focal_reg * focal_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[ele_pkg::PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // stage a: matrix by point products
    // side 0 scores the first point against E^T * second, side 1 the reverse
    ele_pkg::coef_t m [3][3];
    ele_pkg::pt_t   lx [2];
    ele_pkg::pt_t   ly [2];
    logic signed [39:0] p0_next [2][3];
    logic signed [39:0] p1_next [2][3];
    ele_pkg::coef_t     k_next  [2][3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                m[r][c] = e_row_reg[r][c*ele_pkg::COEF_W +: ele_pkg::COEF_W];
            end
        end
        lx[0] = s_tdata[40 +: 20];
        ly[0] = s_tdata[60 +: 20];
        lx[1] = s_tdata[0 +: 20];
        ly[1] = s_tdata[20 +: 20];
        for (int s = 0; s < 2; s++) begin
            for (int j = 0; j < 3; j++) begin
                if (s == 0) begin
                    p0_next[s][j] = m[0][j] * lx[s];
                    p1_next[s][j] = m[1][j] * ly[s];
                    k_next[s][j]  = m[2][j];
                end else begin
                    p0_next[s][j] = m[j][0] * lx[s];
                    p1_next[s][j] = m[j][1] * ly[s];
                    k_next[s][j]  = m[j][2];
                end
            end
        end
    end

    logic signed [39:0] p0_reg [2][3];
    logic signed [39:0] p1_reg [2][3];
    ele_pkg::coef_t     k_reg  [2][3];
    ele_pkg::pt_t       px_a_reg [2];
    ele_pkg::pt_t       py_a_reg [2];

    always_ff @(posedge aclk) begin
        if (ce) begin
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            k_reg    <= k_next;
            px_a_reg <= '{lx[1], lx[0]};
            py_a_reg <= '{ly[1], ly[0]};
        end
    end

    // stage b: line coefficients
    ele_pkg::line_t line_reg [2][3];
    ele_pkg::pt_t   px_b_reg [2];
    ele_pkg::pt_t   py_b_reg [2];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int s = 0; s < 2; s++) begin
                for (int j = 0; j < 3; j++) begin
                    line_reg[s][j] <= $signed({{2{p0_reg[s][j][39]}}, p0_reg[s][j]})
                                    + $signed({{2{p1_reg[s][j][39]}}, p1_reg[s][j]})
                                    + $signed({{6{k_reg[s][j][19]}}, k_reg[s][j], 16'b0});
                end
            end
            px_b_reg <= px_a_reg;
            py_b_reg <= py_a_reg;
        end
    end

    // stage c: point by line partial products, normal magnitudes
    logic signed [41:0] dl_next [2][2];
    logic signed [40:0] dh_next [2][2];
    logic [ele_pkg::MAG_W-1:0] nm_next [2][2];

    always_comb begin
        logic signed [21:0] lo;
        logic signed [20:0] hi;
        ele_pkg::line_t     neg;
        ele_pkg::pt_t       pt;
        for (int s = 0; s < 2; s++) begin
            for (int j = 0; j < 2; j++) begin
                pt  = (j == 0) ? px_b_reg[s] : py_b_reg[s];
                lo  = $signed({1'b0, line_reg[s][j][20:0]});
                hi  = line_reg[s][j][41:21];
                dl_next[s][j] = pt * lo;
                dh_next[s][j] = pt * hi;
                neg = -line_reg[s][j];
                nm_next[s][j] = line_reg[s][j][41] ? neg[ele_pkg::MAG_W-1:0]
                                                   : line_reg[s][j][ele_pkg::MAG_W-1:0];
            end
        end
    end

    logic signed [41:0] dl_reg [2][2];
    logic signed [40:0] dh_reg [2][2];
    logic [ele_pkg::MAG_W-1:0] nm_reg [2][2];
    ele_pkg::line_t lc_reg [2];

    always_ff @(posedge aclk) begin
        if (ce) begin
            dl_reg <= dl_next;
            dh_reg <= dh_next;
            nm_reg <= nm_next;
            lc_reg <= '{line_reg[0][2], line_reg[1][2]};
        end
    end

    // stage d: signed distance numerator, square partials of the normal
    logic signed [ele_pkg::D_W-1:0] d_reg [2];
    logic [39:0] sq_reg [2][2][3];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int s = 0; s < 2; s++) begin
                d_reg[s] <= $signed({dh_reg[s][0][40], dh_reg[s][0], 21'b0})
                          + $signed({{21{dl_reg[s][0][41]}}, dl_reg[s][0]})
                          + $signed({dh_reg[s][1][40], dh_reg[s][1], 21'b0})
                          + $signed({{21{dl_reg[s][1][41]}}, dl_reg[s][1]})
                          + $signed({{5{lc_reg[s][41]}}, lc_reg[s], 16'b0});
                for (int j = 0; j < 2; j++) begin
                    sq_reg[s][j][0] <= nm_reg[s][j][39:20] * nm_reg[s][j][39:20];
                    sq_reg[s][j][1] <= nm_reg[s][j][39:20] * nm_reg[s][j][19:0];
                    sq_reg[s][j][2] <= nm_reg[s][j][19:0]  * nm_reg[s][j][19:0];
                end
            end
        end
    end

    // stage e: |d| and a^2 + b^2
    logic [ele_pkg::DMAG_W-1:0] dm_reg [2];
    logic [ele_pkg::DEN_W-1:0]  den_e_reg [2];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int s = 0; s < 2; s++) begin
                dm_reg[s] <= d_reg[s][ele_pkg::D_W-1] ? ele_pkg::DMAG_W'(-d_reg[s])
                                                      : ele_pkg::DMAG_W'(d_reg[s]);
                den_e_reg[s] <= ele_pkg::DEN_W'({sq_reg[s][0][0], 40'b0})
                              + ele_pkg::DEN_W'({sq_reg[s][0][1], 21'b0})
                              + ele_pkg::DEN_W'(sq_reg[s][0][2])
                              + ele_pkg::DEN_W'({sq_reg[s][1][0], 40'b0})
                              + ele_pkg::DEN_W'({sq_reg[s][1][1], 21'b0})
                              + ele_pkg::DEN_W'(sq_reg[s][1][2]);
            end
        end
    end

    // stage f: d^2 partials, zero normal test
    logic [61:0] dsp_reg [2][3];
    logic [ele_pkg::DEN_W-1:0] den_f_reg [2];
    logic zero_f_reg [2];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int s = 0; s < 2; s++) begin
                dsp_reg[s][0] <= dm_reg[s][61:31] * dm_reg[s][61:31];
                dsp_reg[s][1] <= dm_reg[s][61:31] * dm_reg[s][30:0];
                dsp_reg[s][2] <= dm_reg[s][30:0]  * dm_reg[s][30:0];
                den_f_reg[s]  <= den_e_reg[s];
                zero_f_reg[s] <= (den_e_reg[s] == '0);
            end
        end
    end

    // stage g: d^2
    logic [ele_pkg::DSQ_W-1:0] dsq_reg [2];
    logic [ele_pkg::DEN_W-1:0] den_g_reg [2];
    logic zero_g_reg [2];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int s = 0; s < 2; s++) begin
                dsq_reg[s] <= ele_pkg::DSQ_W'({dsp_reg[s][0], 62'b0})
                            + ele_pkg::DSQ_W'({dsp_reg[s][1], 32'b0})
                            + ele_pkg::DSQ_W'(dsp_reg[s][2]);
            end
            den_g_reg  <= den_f_reg;
            zero_g_reg <= zero_f_reg;
        end
    end

    // stage h: d^2 * f^2 partials, 31-bit slices
    logic [62:0] np_reg [2][4];
    logic [ele_pkg::DEN_W-1:0] den_h_reg [2];
    logic zero_h_reg [2];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int s = 0; s < 2; s++) begin
                for (int i = 0; i < 4; i++) begin
                    np_reg[s][i] <= dsq_reg[s][31*i +: 31] * f2_reg;
                end
            end
            den_h_reg  <= den_g_reg;
            zero_h_reg <= zero_g_reg;
        end
    end

    // stage i: numerator with the 2^32 of the divisor already taken out
    logic [ele_pkg::NUM_W-1:0] num_next [2];
    logic [ele_pkg::NH_W-1:0]  nh_reg [2];
    logic [ele_pkg::DEN_W-1:0] den_i_reg [2];
    logic zero_i_reg [2];

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            num_next[s] = '0;
            for (int i = 0; i < 4; i++) begin
                num_next[s] = num_next[s] + (ele_pkg::NUM_W'(np_reg[s][i]) << (31*i));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int s = 0; s < 2; s++) begin
                nh_reg[s] <= num_next[s][ele_pkg::NUM_W-1:32];
            end
            den_i_reg  <= den_h_reg;
            zero_i_reg <= zero_h_reg;
        end
    end

    // stage j and divider: quotient must fit 32 bits, else saturate
    logic [ele_pkg::REM_W-1:0] dr_reg  [ND+1][2];
    logic [31:0]               dlo_reg [ND+1][2];
    logic [31:0]               dq_reg  [ND+1][2];
    logic [ele_pkg::DEN_W-1:0] dden_reg [ND+1][2];
    logic                      dsat_reg [ND+1][2];
    logic                      dzero_reg [ND+1][2];
    logic [ele_pkg::REM_W-1:0] trial [ND+1][2];
    logic                      fits  [ND+1][2];

    always_comb begin
        for (int k = 0; k <= ND; k++) begin
            for (int s = 0; s < 2; s++) begin
                trial[k][s] = {dr_reg[k][s][ele_pkg::REM_W-2:0], dlo_reg[k][s][31]};
                fits[k][s]  = trial[k][s] >= ele_pkg::REM_W'(dden_reg[k][s]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int s = 0; s < 2; s++) begin
                dsat_reg[0][s]  <= nh_reg[s][ele_pkg::NH_W-1:32]
                                   >= (ele_pkg::NH_W-32)'(den_i_reg[s]);
                dr_reg[0][s]    <= nh_reg[s][32 +: ele_pkg::REM_W];
                dlo_reg[0][s]   <= nh_reg[s][31:0];
                dq_reg[0][s]    <= '0;
                dden_reg[0][s]  <= den_i_reg[s];
                dzero_reg[0][s] <= zero_i_reg[s];
            end
            for (int k = 1; k <= ND; k++) begin
                for (int s = 0; s < 2; s++) begin
                    dr_reg[k][s]    <= fits[k-1][s]
                                       ? trial[k-1][s] - ele_pkg::REM_W'(dden_reg[k-1][s])
                                       : trial[k-1][s];
                    dlo_reg[k][s]   <= {dlo_reg[k-1][s][30:0], 1'b0};
                    dq_reg[k][s]    <= {dq_reg[k-1][s][30:0], fits[k-1][s]};
                    dden_reg[k][s]  <= dden_reg[k-1][s];
                    dsat_reg[k][s]  <= dsat_reg[k-1][s];
                    dzero_reg[k][s] <= dzero_reg[k-1][s];
                end
            end
        end
    end

    // output register
    logic [ele_pkg::ERR_W-1:0] e0, e1;
    logic [ele_pkg::ERR_W-1:0] err_reg;
    logic                      deg_reg;

    assign e0 = dsat_reg[ND][0] ? ele_pkg::ERR_SAT : dq_reg[ND][0];
    assign e1 = dsat_reg[ND][1] ? ele_pkg::ERR_SAT : dq_reg[ND][1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            deg_reg <= dzero_reg[ND][0] || dzero_reg[ND][1];
            if (dzero_reg[ND][0] || dzero_reg[ND][1]) begin
                err_reg <= ele_pkg::ERR_SAT;
            end else begin
                err_reg <= (e0 > e1) ? e0 : e1;
            end
        end
    end

    assign m_tvalid   = vld_reg[ele_pkg::PIPE_DEPTH-1];
    assign m_tdata    = err_reg;
    assign m_tuser[0] = deg_reg;

endmodule

[rtl/ele_checker.sv]
module ele_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [31:0]                   m_tdata,
    input logic [0:0]                    m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // degenerate items saturate
    a_deg_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'hFFFF_FFFF)
        else $error("degenerate item not saturated");

    // pipe only holds when the output is blocked
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input refused with output free");

    // nothing comes out straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind epipolar_line_error ele_checker u_ele_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
